@@ rtl/lrc_pkg.sv @@
// Shared types and constants for the line rectangle clipper.
package lrc_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Register reset values
  localparam int RESET_LEFT   = 0;
  localparam int RESET_TOP    = 0;
  localparam int RESET_RIGHT  = 639;
  localparam int RESET_BOTTOM = 479;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // Coordinate slots carried through a pass
  localparam int SLOT_BSX  = 0;   // pass entry coordinates, used on failure
  localparam int SLOT_BSY  = 1;
  localparam int SLOT_BEX  = 2;
  localparam int SLOT_BEY  = 3;
  localparam int SLOT_PA   = 4;   // ordered: low end on pass axis
  localparam int SLOT_SA   = 5;
  localparam int SLOT_PC   = 6;   // ordered: high end on pass axis
  localparam int SLOT_SC   = 7;
  localparam int NUM_SLOTS = 8;

  // active: segment still being clipped; verdict: outcome when not active
  typedef struct packed {
    logic active;
    logic verdict;
  } lrc_flags_t;

endpackage

@@ rtl/lrc_step.sv @@
// One boundary of a clip pass: conditional interpolation through a pipelined divider.
module lrc_step #(
  parameter int W = lrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  upper,
  input  logic signed [W-1:0]   bound,
  input  logic                  in_valid,
  input  lrc_pkg::lrc_flags_t   in_flags,
  input  logic signed [W-1:0]   in_pts [lrc_pkg::NUM_SLOTS],
  output logic                  out_valid,
  output lrc_pkg::lrc_flags_t   out_flags,
  output logic signed [W-1:0]   out_pts [lrc_pkg::NUM_SLOTS]
);

  logic signed [W-1:0] pa, pc, sa, sc;
  logic                take;
  logic signed [W:0]   dv;
  logic [W:0]          num, den, mag;
  logic [2*W:0]        prod;

  always_comb begin
    pa   = in_pts[lrc_pkg::SLOT_PA];
    sa   = in_pts[lrc_pkg::SLOT_SA];
    pc   = in_pts[lrc_pkg::SLOT_PC];
    sc   = in_pts[lrc_pkg::SLOT_SC];
    take = in_flags.active && (pa < bound) && (pc >= bound);
    dv   = {sc[W-1], sc} - {sa[W-1], sa};
    num  = take ? ({pc[W-1], pc} - {bound[W-1], bound}) : '0;
    den  = take ? ({pc[W-1], pc} - {pa[W-1], pa}) : (W+1)'(1);
    mag  = dv[W] ? (W+1)'(-dv) : (W+1)'(dv);
    prod = {{(W+1){1'b0}}, mag[W-1:0]} * {{W{1'b0}}, num};
  end

  // Stage 0 holds the product split into partial remainder and pending bits.
  // The quotient is known to be below 2^W, so only W restoring steps remain.
  logic [W:0]          dr     [W+1];
  logic [W-1:0]        dl     [W+1];
  logic [W-1:0]        dq     [W+1];
  logic [W:0]          dh     [W+1];
  logic                dneg   [W+1];
  logic                dtake  [W+1];
  logic                dvalid [W+1];
  lrc_pkg::lrc_flags_t dflags [W+1];
  logic signed [W-1:0] dpts   [W+1][lrc_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid[0] <= 1'b0;
    end else if (en) begin
      dvalid[0] <= in_valid;
    end
    if (en) begin
      dr[0]     <= prod[2*W:W];
      dl[0]     <= prod[W-1:0];
      dq[0]     <= '0;
      dh[0]     <= den;
      dneg[0]   <= dv[W];
      dtake[0]  <= take;
      dflags[0] <= in_flags;
      dpts[0]   <= in_pts;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W+1:0] trial;
    logic         fits;

    assign trial = {dr[k], dl[k][W-1]};
    assign fits  = trial >= {1'b0, dh[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dvalid[k+1] <= 1'b0;
      end else if (en) begin
        dvalid[k+1] <= dvalid[k];
      end
      if (en) begin
        dr[k+1]     <= fits ? (W+1)'(trial - {1'b0, dh[k]}) : trial[W:0];
        dl[k+1]     <= {dl[k][W-2:0], 1'b0};
        dq[k+1]     <= {dq[k][W-2:0], fits};
        dh[k+1]     <= dh[k];
        dneg[k+1]   <= dneg[k];
        dtake[k+1]  <= dtake[k];
        dflags[k+1] <= dflags[k];
        dpts[k+1]   <= dpts[k];
      end
    end
  end

  logic [W:0]          qs, nv;
  logic signed [W-1:0] out_pts_next [lrc_pkg::NUM_SLOTS];

  always_comb begin
    qs = dneg[W] ? ((W+1)'(0) - {1'b0, dq[W]}) : {1'b0, dq[W]};
    nv = {dpts[W][lrc_pkg::SLOT_SC][W-1], dpts[W][lrc_pkg::SLOT_SC]} - qs;
    out_pts_next = dpts[W];
    if (dtake[W]) begin
      if (upper) begin
        out_pts_next[lrc_pkg::SLOT_SC] = nv[W-1:0];
        out_pts_next[lrc_pkg::SLOT_PC] = bound;
      end else begin
        out_pts_next[lrc_pkg::SLOT_SA] = nv[W-1:0];
        out_pts_next[lrc_pkg::SLOT_PA] = bound;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvalid[W];
    end
    if (en) begin
      out_flags <= dflags[W];
      out_pts   <= out_pts_next;
    end
  end

endmodule

@@ rtl/line_rectangle_clipper.sv @@
// Line segment clipper against a configured rectangle, rows first, then columns.
// Four interpolation steps of COORD_WIDTH+2 stages each (operand stage, one
// restoring-division stage per quotient bit, result stage), plus two setup, one
// finish and one output stage.
// Throughput one segment per cycle; a stall at the output freezes the whole pipeline.
// Synchronous reset clears valid bits and loads the rectangle (0,0)-(639,479).
module line_rectangle_clipper #(
  parameter int COORD_WIDTH = lrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          visible,
  output logic signed [COORD_WIDTH-1:0] clipped_start_x,
  output logic signed [COORD_WIDTH-1:0] clipped_start_y,
  output logic signed [COORD_WIDTH-1:0] clipped_end_x,
  output logic signed [COORD_WIDTH-1:0] clipped_end_y
);

  localparam int W = COORD_WIDTH;
  localparam int NS = lrc_pkg::NUM_SLOTS;

  // ---------------- configuration ----------------
  logic signed [W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= W'(lrc_pkg::RESET_LEFT);
      clip_top    <= W'(lrc_pkg::RESET_TOP);
      clip_right  <= W'(lrc_pkg::RESET_RIGHT);
      clip_bottom <= W'(lrc_pkg::RESET_BOTTOM);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        lrc_pkg::REG_LEFT:   clip_left   <= pwdata[W-1:0];
        lrc_pkg::REG_TOP:    clip_top    <= pwdata[W-1:0];
        lrc_pkg::REG_RIGHT:  clip_right  <= pwdata[W-1:0];
        lrc_pkg::REG_BOTTOM: clip_bottom <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lrc_pkg::REG_LEFT:   prdata = 32'(clip_left);
      lrc_pkg::REG_TOP:    prdata = 32'(clip_top);
      lrc_pkg::REG_RIGHT:  prdata = 32'(clip_right);
      lrc_pkg::REG_BOTTOM: prdata = 32'(clip_bottom);
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------- row pass setup ----------------
  logic                p1_valid;
  lrc_pkg::lrc_flags_t p1_flags, p1_flags_next;
  logic signed [W-1:0] p1_pts [NS];
  logic signed [W-1:0] p1_pts_next [NS];
  logic                p1_eq, p1_out, p1_sw;

  always_comb begin
    p1_eq  = start_y == end_y;
    p1_out = (start_y < clip_top && end_y < clip_top) ||
             (start_y > clip_bottom && end_y > clip_bottom);
    p1_sw  = end_y < start_y;
    p1_flags_next.active  = !p1_eq && !p1_out;
    p1_flags_next.verdict = p1_eq && !(start_y < clip_top || start_y > clip_bottom);
    p1_pts_next[lrc_pkg::SLOT_BSX] = start_x;
    p1_pts_next[lrc_pkg::SLOT_BSY] = start_y;
    p1_pts_next[lrc_pkg::SLOT_BEX] = end_x;
    p1_pts_next[lrc_pkg::SLOT_BEY] = end_y;
    p1_pts_next[lrc_pkg::SLOT_PA]  = p1_sw ? end_y   : start_y;
    p1_pts_next[lrc_pkg::SLOT_SA]  = p1_sw ? end_x   : start_x;
    p1_pts_next[lrc_pkg::SLOT_PC]  = p1_sw ? start_y : end_y;
    p1_pts_next[lrc_pkg::SLOT_SC]  = p1_sw ? start_x : end_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
    end
    if (en) begin
      p1_flags <= p1_flags_next;
      p1_pts   <= p1_pts_next;
    end
  end

  // ---------------- row pass boundaries ----------------
  logic                s1a_valid, s1b_valid;
  lrc_pkg::lrc_flags_t s1a_flags, s1b_flags;
  logic signed [W-1:0] s1a_pts [NS];
  logic signed [W-1:0] s1b_pts [NS];

  lrc_step #(.W(W)) u_step_top (
    .clk(clk), .rst(rst), .en(en), .upper(1'b0), .bound(clip_top),
    .in_valid(p1_valid), .in_flags(p1_flags), .in_pts(p1_pts),
    .out_valid(s1a_valid), .out_flags(s1a_flags), .out_pts(s1a_pts)
  );

  lrc_step #(.W(W)) u_step_bottom (
    .clk(clk), .rst(rst), .en(en), .upper(1'b1), .bound(clip_bottom),
    .in_valid(s1a_valid), .in_flags(s1a_flags), .in_pts(s1a_pts),
    .out_valid(s1b_valid), .out_flags(s1b_flags), .out_pts(s1b_pts)
  );

  // ---------------- row pass finish ----------------
  logic                f1_valid, f1_vis, f1_vis_next, f1_take;
  logic signed [W-1:0] f1_sx, f1_sy, f1_ex, f1_ey;

  always_comb begin
    f1_vis_next = s1b_flags.active ?
                  !(s1b_pts[lrc_pkg::SLOT_PA] < clip_top ||
                    s1b_pts[lrc_pkg::SLOT_PC] > clip_bottom) :
                  s1b_flags.verdict;
    f1_take = s1b_flags.active && f1_vis_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= s1b_valid;
    end
    if (en) begin
      f1_vis <= f1_vis_next;
      f1_sx  <= f1_take ? s1b_pts[lrc_pkg::SLOT_SA] : s1b_pts[lrc_pkg::SLOT_BSX];
      f1_sy  <= f1_take ? s1b_pts[lrc_pkg::SLOT_PA] : s1b_pts[lrc_pkg::SLOT_BSY];
      f1_ex  <= f1_take ? s1b_pts[lrc_pkg::SLOT_SC] : s1b_pts[lrc_pkg::SLOT_BEX];
      f1_ey  <= f1_take ? s1b_pts[lrc_pkg::SLOT_PC] : s1b_pts[lrc_pkg::SLOT_BEY];
    end
  end

  // ---------------- column pass setup ----------------
  logic                p2_valid;
  lrc_pkg::lrc_flags_t p2_flags, p2_flags_next;
  logic signed [W-1:0] p2_pts [NS];
  logic signed [W-1:0] p2_pts_next [NS];
  logic                p2_eq, p2_out, p2_sw;

  always_comb begin
    p2_eq  = f1_sx == f1_ex;
    p2_out = (f1_sx < clip_left && f1_ex < clip_left) ||
             (f1_sx > clip_right && f1_ex > clip_right);
    p2_sw  = f1_ex < f1_sx;
    // a segment already lost in the row pass just carries its coordinates
    p2_flags_next.active  = f1_vis && !p2_eq && !p2_out;
    p2_flags_next.verdict = f1_vis && p2_eq &&
                            !(f1_sx < clip_left || f1_sx > clip_right);
    p2_pts_next[lrc_pkg::SLOT_BSX] = f1_sx;
    p2_pts_next[lrc_pkg::SLOT_BSY] = f1_sy;
    p2_pts_next[lrc_pkg::SLOT_BEX] = f1_ex;
    p2_pts_next[lrc_pkg::SLOT_BEY] = f1_ey;
    p2_pts_next[lrc_pkg::SLOT_PA]  = p2_sw ? f1_ex : f1_sx;
    p2_pts_next[lrc_pkg::SLOT_SA]  = p2_sw ? f1_ey : f1_sy;
    p2_pts_next[lrc_pkg::SLOT_PC]  = p2_sw ? f1_sx : f1_ex;
    p2_pts_next[lrc_pkg::SLOT_SC]  = p2_sw ? f1_sy : f1_ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= f1_valid;
    end
    if (en) begin
      p2_flags <= p2_flags_next;
      p2_pts   <= p2_pts_next;
    end
  end

  // ---------------- column pass boundaries ----------------
  logic                s2a_valid, s2b_valid;
  lrc_pkg::lrc_flags_t s2a_flags, s2b_flags;
  logic signed [W-1:0] s2a_pts [NS];
  logic signed [W-1:0] s2b_pts [NS];

  lrc_step #(.W(W)) u_step_left (
    .clk(clk), .rst(rst), .en(en), .upper(1'b0), .bound(clip_left),
    .in_valid(p2_valid), .in_flags(p2_flags), .in_pts(p2_pts),
    .out_valid(s2a_valid), .out_flags(s2a_flags), .out_pts(s2a_pts)
  );

  lrc_step #(.W(W)) u_step_right (
    .clk(clk), .rst(rst), .en(en), .upper(1'b1), .bound(clip_right),
    .in_valid(s2a_valid), .in_flags(s2a_flags), .in_pts(s2a_pts),
    .out_valid(s2b_valid), .out_flags(s2b_flags), .out_pts(s2b_pts)
  );

  // ---------------- output register ----------------
  logic vis_next, out_take;

  always_comb begin
    vis_next = s2b_flags.active ?
               !(s2b_pts[lrc_pkg::SLOT_PA] < clip_left ||
                 s2b_pts[lrc_pkg::SLOT_PC] > clip_right) :
               s2b_flags.verdict;
    out_take = s2b_flags.active && vis_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2b_valid;
    end
    if (en) begin
      visible         <= vis_next;
      clipped_start_x <= out_take ? s2b_pts[lrc_pkg::SLOT_PA] : s2b_pts[lrc_pkg::SLOT_BSX];
      clipped_start_y <= out_take ? s2b_pts[lrc_pkg::SLOT_SA] : s2b_pts[lrc_pkg::SLOT_BSY];
      clipped_end_x   <= out_take ? s2b_pts[lrc_pkg::SLOT_PC] : s2b_pts[lrc_pkg::SLOT_BEX];
      clipped_end_y   <= out_take ? s2b_pts[lrc_pkg::SLOT_SC] : s2b_pts[lrc_pkg::SLOT_BEY];
    end
  end

  // ---------------- assertions ----------------
  // interpolation never crosses the endpoints over along the pass axis
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    s1b_valid && s1b_flags.active |->
      s1b_pts[lrc_pkg::SLOT_PA] <= s1b_pts[lrc_pkg::SLOT_PC])
    else $error("row pass endpoints out of order");

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    s2b_valid && s2b_flags.active |->
      s2b_pts[lrc_pkg::SLOT_PA] <= s2b_pts[lrc_pkg::SLOT_PC])
    else $error("column pass endpoints out of order");

  // input is held back only while a finished transfer waits at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // a segment lost in the row pass stays invisible
  a_lost_stays: assert property (@(posedge clk) disable iff (rst)
    f1_valid && !f1_vis && en |=> !p2_flags.active && !p2_flags.verdict)
    else $error("row pass failure not carried into column pass");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for line_rectangle_clipper: directed table, random segments, scoreboard.
module tb;

  localparam int CW = lrc_pkg::COORD_WIDTH_DEF;
  localparam longint CMIN = -(longint'(1) <<< (CW - 1));
  localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    bit     vis;
    coord_t sx, sy, ex, ey;
  } clip_result_t;

  typedef struct {
    coord_t       sx, sy, ex, ey;
    bit           typed;
    clip_result_t res;
  } seg_row_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall, out_valid, out_stall;
  coord_t      start_x, start_y, end_x, end_y;
  logic        visible;
  coord_t      clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;

  line_rectangle_clipper dut (.*);

  // clip rectangle as the block holds it
  longint rect_left = lrc_pkg::RESET_LEFT, rect_top = lrc_pkg::RESET_TOP;
  longint rect_right = lrc_pkg::RESET_RIGHT, rect_bottom = lrc_pkg::RESET_BOTTOM;

  clip_result_t pending_clips[$];
  int errors = 0;
  int segs_sent = 0;
  int results_seen = 0;
  int visible_seen = 0;
  int rects_used = 1;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one axis of the clip; ax 0 = columns, 1 = rows; pt[k] = {x, y}
  function automatic bit clip_axis(inout longint pt[2][2], input int ax,
                                   input longint lo, input longint hi);
    int     ot;
    longint p0, p1, pa, sa, pc, sc;
    ot = 1 - ax;
    p0 = pt[0][ax];
    p1 = pt[1][ax];
    if (p0 == p1) return !(p0 < lo || p0 > hi);
    if ((p0 < lo && p1 < lo) || (p0 > hi && p1 > hi)) return 0;
    if (p0 < p1) begin
      pa = p0; sa = pt[0][ot]; pc = p1; sc = pt[1][ot];
    end else begin
      pa = p1; sa = pt[1][ot]; pc = p0; sc = pt[0][ot];
    end
    // product fits easily in 64 bits; SV division truncates toward zero
    if (pa < lo && pc >= lo) begin
      sa = sc - ((sc - sa) * (pc - lo)) / (pc - pa);
      pa = lo;
    end
    if (pa < hi && pc >= hi) begin
      sc = sc - ((sc - sa) * (pc - hi)) / (pc - pa);
      pc = hi;
    end
    if (pa < lo || pc > hi) return 0;
    pt[0][ax] = pa; pt[0][ot] = sa;
    pt[1][ax] = pc; pt[1][ot] = sc;
    return 1;
  endfunction

  function automatic clip_result_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint       pt[2][2];
    clip_result_t r;
    pt[0][0] = sx; pt[0][1] = sy;
    pt[1][0] = ex; pt[1][1] = ey;
    r.vis = clip_axis(pt, 1, rect_top, rect_bottom);
    if (r.vis) r.vis = clip_axis(pt, 0, rect_left, rect_right);
    r.sx = coord_t'(pt[0][0]);
    r.sy = coord_t'(pt[0][1]);
    r.ex = coord_t'(pt[1][0]);
    r.ey = coord_t'(pt[1][1]);
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, longint val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lrc_pkg::REG_LEFT:   rect_left   = val;
      lrc_pkg::REG_TOP:    rect_top    = val;
      lrc_pkg::REG_RIGHT:  rect_right  = val;
      lrc_pkg::REG_BOTTOM: rect_bottom = val;
      default: ;
    endcase
  endtask

  // hold the sender until every pending clip has returned, then let the pipe empty
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_clips.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_segment(seg_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= row.sx;
    start_y  <= row.sy;
    end_x    <= row.ex;
    end_y    <= row.ey;
    do @(posedge clk); while (in_stall);
    pending_clips.push_back(row.typed ? row.res : clip_segment(row.sx, row.sy, row.ex, row.ey));
    segs_sent++;
  endtask

  function automatic coord_t near_coord(longint a, longint b);
    longint lo, hi, v;
    lo = (a < b ? a : b) - 80;
    hi = (a < b ? b : a) + 80;
    v = lo + longint'($urandom_range(int'(hi - lo)));
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return coord_t'(v);
  endfunction

  function automatic seg_row_t random_segment();
    seg_row_t row;
    int       pick;
    pick = $urandom_range(99);
    row.typed = 0;
    if (pick < 80 && pick >= 55) begin
      row.sx = coord_t'($urandom); row.sy = coord_t'($urandom);
      row.ex = coord_t'($urandom); row.ey = coord_t'($urandom);
    end else begin
      row.sx = near_coord(rect_left, rect_right);
      row.ex = near_coord(rect_left, rect_right);
      row.sy = near_coord(rect_top, rect_bottom);
      row.ey = near_coord(rect_top, rect_bottom);
      if (pick >= 80 && pick < 88) row.ey = row.sy;    // horizontal
      else if (pick >= 88 && pick < 96) row.ex = row.sx;
      else if (pick >= 96) begin
        row.ex = row.sx; row.ey = row.sy;                // single point
      end
    end
    return row;
  endfunction

  always @(posedge clk) out_stall <= !rst && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    clip_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (visible) visible_seen++;
      if (pending_clips.size() == 0) begin
        $error("result transfer with no pending clip");
        errors++;
      end else begin
        want = pending_clips.pop_front();
        if (visible !== want.vis) begin
          $error("visible: expected %0d, got %0d", want.vis, visible); errors++;
        end
        if (clipped_start_x !== want.sx) begin
          $error("clipped_start_x: expected %0d, got %0d", want.sx, clipped_start_x); errors++;
        end
        if (clipped_start_y !== want.sy) begin
          $error("clipped_start_y: expected %0d, got %0d", want.sy, clipped_start_y); errors++;
        end
        if (clipped_end_x !== want.ex) begin
          $error("clipped_end_x: expected %0d, got %0d", want.ex, clipped_end_x); errors++;
        end
        if (clipped_end_y !== want.ey) begin
          $error("clipped_end_y: expected %0d, got %0d", want.ey, clipped_end_y); errors++;
        end
      end
    end
  end

  // default rectangle (0,0)-(639,479); typed rows are read straight off the clip rules
  seg_row_t directed[] = '{
    '{10, 20, 100, 200, 1, '{1, 10, 20, 100, 200}},
    '{100, 200, 10, 20, 1, '{1, 10, 20, 100, 200}},     // endpoints come back ordered
    '{5, -10, 50, -3, 1, '{0, 5, -10, 50, -3}},         // wholly above
    '{-50, 100, 700, 100, 1, '{1, 0, 100, 639, 100}},   // horizontal, cut both sides
    '{700, 0, 700, 10, 1, '{0, 700, 0, 700, 10}},       // vertical, right of box
    '{5, 5, 5, 5, 1, '{1, 5, 5, 5, 5}},                 // single point inside
    '{-32768, -32768, -32768, -32768, 1, '{0, -32768, -32768, -32768, -32768}},
    '{32767, 32767, 32767, 32767, 1, '{0, 32767, 32767, 32767, 32767}},
    '{0, 0, 639, 479, 1, '{1, 0, 0, 639, 479}},
    '{-32768, -32768, 32767, 32767, 0, '{0, 0, 0, 0, 0}},
    '{32767, -32768, -32768, 32767, 0, '{0, 0, 0, 0, 0}},
    '{-32768, 240, 32767, 241, 0, '{0, 0, 0, 0, 0}},
    '{320, -32768, 321, 32767, 0, '{0, 0, 0, 0, 0}},
    '{-100, -100, 800, 600, 0, '{0, 0, 0, 0, 0}},
    '{800, 600, -100, -100, 0, '{0, 0, 0, 0, 0}},
    '{-10, 470, 30, 500, 0, '{0, 0, 0, 0, 0}},
    '{-200, 100, 100, -200, 0, '{0, 0, 0, 0, 0}},
    '{650, 240, 700, 300, 0, '{0, 0, 0, 0, 0}},
    '{-1, -1, 640, 480, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    longint lo, hi;
    rst = 1'b1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    in_valid <= 0; start_x <= '0; start_y <= '0; end_x <= '0; end_y <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_segment(directed[i]);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin reg_write(lrc_pkg::REG_LEFT, CMIN); reg_write(lrc_pkg::REG_TOP, CMIN);
                   reg_write(lrc_pkg::REG_RIGHT, CMAX); reg_write(lrc_pkg::REG_BOTTOM, CMAX); end
          2: begin reg_write(lrc_pkg::REG_LEFT, 200); reg_write(lrc_pkg::REG_TOP, 300); // inverted
                   reg_write(lrc_pkg::REG_RIGHT, 100); reg_write(lrc_pkg::REG_BOTTOM, 50); end
          3: begin reg_write(lrc_pkg::REG_LEFT, 7); reg_write(lrc_pkg::REG_TOP, -7);
                   reg_write(lrc_pkg::REG_RIGHT, 7); reg_write(lrc_pkg::REG_BOTTOM, -7); end
          default: begin
            lo = longint'($urandom_range(60000)) + CMIN;
            hi = lo + longint'($urandom_range(ph == 4 ? 3000 : 40));
            if (hi > CMAX) hi = CMAX;
            reg_write(lrc_pkg::REG_LEFT, lo); reg_write(lrc_pkg::REG_RIGHT, hi);
            lo = longint'($urandom_range(60000)) + CMIN;
            hi = lo + longint'($urandom_range(2000));
            if (hi > CMAX) hi = CMAX;
            reg_write(lrc_pkg::REG_TOP, lo); reg_write(lrc_pkg::REG_BOTTOM, hi);
          end
        endcase
        rects_used++;
      end
      for (int k = 0; k < 210; k++) begin
        case (k / 70)
          0: begin send_idle_pct = 20; stall_pct = 76; end
          1: begin send_idle_pct = 76; stall_pct = 20; end
          default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
        if (ph == 0 && k == 100) drain();
        send_segment(random_segment());
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    do @(posedge clk); while (pending_clips.size() != 0);
    repeat (100) @(posedge clk);
    $display("Clipped %0d segments against %0d rectangles, %0d results back, %0d visible.",
             segs_sent, rects_used, results_seen, visible_seen);
    $display("Rectangles included the reset box, full range, inverted and single-point cases.");
    if (errors == 0 && pending_clips.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lrc_pkg.sv
rtl/lrc_step.sv
rtl/line_rectangle_clipper.sv
test/tb.sv
